>>> design/pbchd_pkg.sv
package pbchd_pkg;

   localparam int CHUNK_LENGTH = 120;
   localparam int SOFT_WIDTH   = 16;
   localparam int NUM_HYP      = 4;
   localparam int BLOCK_LENGTH = NUM_HYP * CHUNK_LENGTH;
   localparam int GOLD_DISCARD = 1600;
   localparam int LFSR_WIDTH   = 31;
   localparam int CELL_ID_WIDTH = 9;
   localparam int CELL_ID_RESET = 124;

   localparam int SUM_WIDTH     = SOFT_WIDTH + 2;
   localparam int POS_WIDTH     = $clog2(BLOCK_LENGTH);
   localparam int CHUNK_WIDTH   = $clog2(CHUNK_LENGTH);
   localparam int DISCARD_WIDTH = $clog2(GOLD_DISCARD);
   localparam int HYP_WIDTH     = $clog2(NUM_HYP);
   localparam int SUMS_WIDTH    = NUM_HYP * SUM_WIDTH;

   typedef logic signed [SOFT_WIDTH-1:0] soft_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic [POS_WIDTH-1:0]         pos_type;
   typedef logic [CHUNK_WIDTH-1:0]       chunk_type;
   typedef logic [CELL_ID_WIDTH-1:0]     cell_id_type;
   typedef logic [LFSR_WIDTH-1:0]        lfsr_type;

   localparam soft_type SOFT_MIN = {1'b1, {(SOFT_WIDTH-1){1'b0}}};
   localparam soft_type SOFT_MAX = {1'b0, {(SOFT_WIDTH-1){1'b1}}};

   // sequence generator states
   localparam logic [1:0] GEN_IDLE    = 2'd0;
   localparam logic [1:0] GEN_DISCARD = 2'd1;
   localparam logic [1:0] GEN_FILL    = 2'd2;

endpackage

>>> design/pbchd_ram.sv
module pbchd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pbch_gold_descrambler_top.sv
// PBCH Gold sequence descrambler with four-chunk soft combining.
// csr channel: csr_valid/csr_ready carry a new cell id; each write restarts the
//   Gold generator, which discards the first 1600 sequence bits, then writes
//   1920 bits (one sequence bit per cycle) and holds req_stall high meanwhile.
//   csr_ready is low while the generator runs.
// req channel: one signed soft value per word, accepted when req_valid is high
//   and req_stall is low. Words are numbered 0..479 within a block, wrapping.
// rsp channel: one word per accepted soft value, with its block position, the
//   four descrambled hypotheses and the four chunk averages (valid from
//   position 360 on), handed over when rsp_valid is high and rsp_stall is low.
// An accepted word passes through the input register (ram read in flight), the
//   descramble and accumulate registers and the output register.
// Throughput is one word per cycle while the generator is idle; each stage
//   moves on whenever the next stage is empty or moving, so bubbles close up
//   under rsp_stall and a full pipeline just holds. Nothing is lost or repeated.
// After reset the generator builds the sequence for cell 124 (with req_stall
//   high meanwhile); the block position starts at 0 and survives cell id writes.
module pbch_gold_descrambler_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  pbchd_pkg::cell_id_type csr_cell_id,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pbchd_pkg::soft_type    req_soft_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pbchd_pkg::pos_type     rsp_position,
   output pbchd_pkg::soft_type    rsp_descrambled_0,
   output pbchd_pkg::soft_type    rsp_descrambled_1,
   output pbchd_pkg::soft_type    rsp_descrambled_2,
   output pbchd_pkg::soft_type    rsp_descrambled_3,
   output pbchd_pkg::soft_type    rsp_combined_0,
   output pbchd_pkg::soft_type    rsp_combined_1,
   output pbchd_pkg::soft_type    rsp_combined_2,
   output pbchd_pkg::soft_type    rsp_combined_3,
   output logic                   rsp_combined_valid
);

   import pbchd_pkg::*;

   // ---------------- sequence generator ----------------
   logic [1:0]               gen_state_ff, gen_state_in;
   logic [DISCARD_WIDTH-1:0] disc_cnt_ff, disc_cnt_in;
   logic [HYP_WIDTH-1:0]     fill_seg_ff, fill_seg_in;
   pos_type                  fill_addr_ff, fill_addr_in;
   lfsr_type                 lfsr1_ff, lfsr1_in;
   lfsr_type                 lfsr2_ff, lfsr2_in;
   logic                     gen_bit;
   logic                     csr_write;

   assign csr_ready = (gen_state_ff == GEN_IDLE);
   assign csr_write = csr_valid && csr_ready;
   assign gen_bit   = lfsr1_ff[0] ^ lfsr2_ff[0];

   always_comb begin
      gen_state_in = gen_state_ff;
      disc_cnt_in  = disc_cnt_ff;
      fill_seg_in  = fill_seg_ff;
      fill_addr_in = fill_addr_ff;
      lfsr1_in     = {lfsr1_ff[3] ^ lfsr1_ff[0], lfsr1_ff[LFSR_WIDTH-1:1]};
      lfsr2_in     = {lfsr2_ff[3] ^ lfsr2_ff[2] ^ lfsr2_ff[1] ^ lfsr2_ff[0],
                      lfsr2_ff[LFSR_WIDTH-1:1]};
      unique case (gen_state_ff)
         GEN_IDLE: begin
            lfsr1_in = lfsr1_ff;
            lfsr2_in = lfsr2_ff;
            if (csr_write) begin
               gen_state_in = GEN_DISCARD;
               disc_cnt_in  = '0;
               fill_seg_in  = '0;
               fill_addr_in = '0;
               lfsr1_in     = lfsr_type'(1);
               lfsr2_in     = lfsr_type'(csr_cell_id);
            end
         end
         GEN_DISCARD: begin
            disc_cnt_in = disc_cnt_ff + 1'b1;
            if (disc_cnt_ff == DISCARD_WIDTH'(GOLD_DISCARD - 1)) begin
               gen_state_in = GEN_FILL;
            end
         end
         GEN_FILL: begin
            if (fill_addr_ff == pos_type'(BLOCK_LENGTH - 1)) begin
               fill_addr_in = '0;
               fill_seg_in  = fill_seg_ff + 1'b1;
               if (fill_seg_ff == HYP_WIDTH'(NUM_HYP - 1)) begin
                  gen_state_in = GEN_IDLE;
               end
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         default: begin
            gen_state_in = GEN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= GEN_DISCARD;
         disc_cnt_ff  <= '0;
         fill_seg_ff  <= '0;
         fill_addr_ff <= '0;
         lfsr1_ff     <= lfsr_type'(1);
         lfsr2_ff     <= lfsr_type'(CELL_ID_RESET);
      end else begin
         gen_state_ff <= gen_state_in;
         disc_cnt_ff  <= disc_cnt_in;
         fill_seg_ff  <= fill_seg_in;
         fill_addr_ff <= fill_addr_in;
         lfsr1_ff     <= lfsr1_in;
         lfsr2_ff     <= lfsr2_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic en1, en2, en3, en_out;
   logic accept;
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;

   assign en_out    = !out_v_ff || !rsp_stall;
   assign en3       = !s3_v_ff || en_out;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_stall = (gen_state_ff != GEN_IDLE) || !en1;
   assign accept    = req_valid && !req_stall;

   // block position and chunk position
   pos_type   block_pos_ff, block_pos_in;
   chunk_type chunk_pos_ff, chunk_pos_in;

   always_comb begin
      block_pos_in = block_pos_ff;
      chunk_pos_in = chunk_pos_ff;
      if (accept) begin
         block_pos_in = (block_pos_ff == pos_type'(BLOCK_LENGTH - 1)) ?
                        '0 : block_pos_ff + 1'b1;
         chunk_pos_in = (chunk_pos_ff == chunk_type'(CHUNK_LENGTH - 1)) ?
                        '0 : chunk_pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_pos_ff <= '0;
         chunk_pos_ff <= '0;
      end else begin
         block_pos_ff <= block_pos_in;
         chunk_pos_ff <= chunk_pos_in;
      end
   end

   // ---------------- memories ----------------
   logic [NUM_HYP-1:0]    seq_bits;
   logic [SUMS_WIDTH-1:0] sums_rd_data;
   logic [SUMS_WIDTH-1:0] sums_wr_data;
   logic                  sums_wr_en;
   chunk_type             s2_chunk_ff;

   for (genvar h = 0; h < NUM_HYP; h++) begin : g_seq
      pbchd_ram #(
         .WIDTH (1),
         .DEPTH (BLOCK_LENGTH)
      ) u_seq_ram (
         .clock   (clock),
         .wr_en   ((gen_state_ff == GEN_FILL) && (fill_seg_ff == HYP_WIDTH'(h))),
         .wr_addr (fill_addr_ff),
         .wr_data (gen_bit),
         .rd_en   (en1),
         .rd_addr (block_pos_ff),
         .rd_data (seq_bits[h])
      );
   end

   // one row per chunk position, the four hypotheses side by side
   pbchd_ram #(
      .WIDTH (SUMS_WIDTH),
      .DEPTH (CHUNK_LENGTH)
   ) u_sums_ram (
      .clock   (clock),
      .wr_en   (sums_wr_en),
      .wr_addr (s2_chunk_ff),
      .wr_data (sums_wr_data),
      .rd_en   (en1),
      .rd_addr (chunk_pos_ff),
      .rd_data (sums_rd_data)
   );

   // ---------------- stage 1: input word, ram read in flight ----------------
   soft_type  s1_soft_ff;
   pos_type   s1_pos_ff;
   chunk_type s1_chunk_ff;
   logic      s1_first_ff, s1_comb_ff;
   logic      s1_v_in, s1_first_in, s1_comb_in;

   assign s1_v_in     = accept;
   assign s1_first_in = block_pos_ff < pos_type'(CHUNK_LENGTH);
   assign s1_comb_in  = block_pos_ff >= pos_type'(3 * CHUNK_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_soft_ff  <= req_soft_value;
         s1_pos_ff   <= block_pos_ff;
         s1_chunk_ff <= chunk_pos_ff;
         s1_first_ff <= s1_first_in;
         s1_comb_ff  <= s1_comb_in;
      end
   end

   // ---------------- stage 2: descramble ----------------
   soft_type              s2_desc_ff [NUM_HYP];
   soft_type              s2_desc_in [NUM_HYP];
   logic [SUMS_WIDTH-1:0] s2_old_ff;
   pos_type               s2_pos_ff;
   logic                  s2_first_ff, s2_comb_ff;

   always_comb begin
      for (int h = 0; h < NUM_HYP; h++) begin
         if (!seq_bits[h]) begin
            s2_desc_in[h] = s1_soft_ff;
         end else if (s1_soft_ff == SOFT_MIN) begin
            s2_desc_in[h] = SOFT_MAX;
         end else begin
            s2_desc_in[h] = -s1_soft_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_desc_ff  <= s2_desc_in;
         s2_old_ff   <= sums_rd_data;
         s2_pos_ff   <= s1_pos_ff;
         s2_chunk_ff <= s1_chunk_ff;
         s2_first_ff <= s1_first_ff;
         s2_comb_ff  <= s1_comb_ff;
      end
   end

   // ---------------- stage 3: accumulate ----------------
   sum_type  s3_sum_ff [NUM_HYP];
   sum_type  s3_sum_in [NUM_HYP];
   soft_type s3_desc_ff [NUM_HYP];
   pos_type  s3_pos_ff;
   logic     s3_comb_ff;

   always_comb begin
      for (int h = 0; h < NUM_HYP; h++) begin
         if (s2_first_ff) begin
            s3_sum_in[h] = sum_type'(s2_desc_ff[h]);
         end else begin
            s3_sum_in[h] = sum_type'(s2_old_ff[h*SUM_WIDTH +: SUM_WIDTH])
                           + sum_type'(s2_desc_ff[h]);
         end
         sums_wr_data[h*SUM_WIDTH +: SUM_WIDTH] = s3_sum_in[h];
      end
   end

   // the same chunk position comes back only a whole chunk later
   assign sums_wr_en = en3 && s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_sum_ff  <= s3_sum_in;
         s3_desc_ff <= s2_desc_ff;
         s3_pos_ff  <= s2_pos_ff;
         s3_comb_ff <= s2_comb_ff;
      end
   end

   // ---------------- output register ----------------
   soft_type out_desc_ff [NUM_HYP];
   soft_type out_comb_ff [NUM_HYP];
   soft_type out_comb_in [NUM_HYP];
   pos_type  out_pos_ff;
   logic     out_comb_valid_ff;

   // average is the sum shifted down by two, floor rounding
   always_comb begin
      for (int h = 0; h < NUM_HYP; h++) begin
         out_comb_in[h] = s3_comb_ff ? soft_type'(s3_sum_ff[h] >>> 2) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en_out) begin
         out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_desc_ff       <= s3_desc_ff;
         out_comb_ff       <= out_comb_in;
         out_pos_ff        <= s3_pos_ff;
         out_comb_valid_ff <= s3_comb_ff;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_position       = out_pos_ff;
   assign rsp_descrambled_0  = out_desc_ff[0];
   assign rsp_descrambled_1  = out_desc_ff[1];
   assign rsp_descrambled_2  = out_desc_ff[2];
   assign rsp_descrambled_3  = out_desc_ff[3];
   assign rsp_combined_0     = out_comb_ff[0];
   assign rsp_combined_1     = out_comb_ff[1];
   assign rsp_combined_2     = out_comb_ff[2];
   assign rsp_combined_3     = out_comb_ff[3];
   assign rsp_combined_valid = out_comb_valid_ff;

   // ---------------- assertions ----------------
   a_no_accept_while_gen: assert property (@(posedge clock) disable iff (reset)
      (gen_state_ff != GEN_IDLE) |-> !accept)
      else $error("word accepted while sequence generator runs");

   a_comb_valid_pos: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_comb_valid_ff) |-> (out_pos_ff >= pos_type'(3 * CHUNK_LENGTH)))
      else $error("combined result flagged valid before last chunk");

   a_first_chunk: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_first_ff) |-> (s2_pos_ff < pos_type'(CHUNK_LENGTH)))
      else $error("sum restart outside first chunk");

   a_chunk_tracks_block: assert property (@(posedge clock) disable iff (reset)
      (block_pos_ff == '0) |-> (chunk_pos_ff == '0))
      else $error("chunk position out of step with block position");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && block_pos_ff != pos_type'(BLOCK_LENGTH - 1))
         |=> (block_pos_ff == $past(block_pos_ff) + 1'b1))
      else $error("block position did not advance on accept");

endmodule

>>> dv/tb_pbch_gold_descrambler_top.sv
module tb_pbch_gold_descrambler_top;
   import pbchd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      pos_type  position;
      soft_type descr_0;
      soft_type descr_1;
      soft_type descr_2;
      soft_type descr_3;
      soft_type comb_0;
      soft_type comb_1;
      soft_type comb_2;
      soft_type comb_3;
      logic     comb_valid;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   cell_id_type csr_cell_id = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   soft_type    req_soft_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pos_type     rsp_position;
   soft_type    rsp_descrambled_0, rsp_descrambled_1, rsp_descrambled_2, rsp_descrambled_3;
   soft_type    rsp_combined_0, rsp_combined_1, rsp_combined_2, rsp_combined_3;
   logic        rsp_combined_valid;

   // predictor state
   logic        gold_bits [0:4*BLOCK_LENGTH-1];
   sum_type     chunk_sums [0:BLOCK_LENGTH-1];
   int          block_pos;

   soft_type     soft_queue [$];
   rsp_word_type expected_words [$];

   logic        req_took = 1'b0;
   logic        csr_took = 1'b0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   pbch_gold_descrambler_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_cell_id        (csr_cell_id),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_soft_value     (req_soft_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position       (rsp_position),
      .rsp_descrambled_0  (rsp_descrambled_0),
      .rsp_descrambled_1  (rsp_descrambled_1),
      .rsp_descrambled_2  (rsp_descrambled_2),
      .rsp_descrambled_3  (rsp_descrambled_3),
      .rsp_combined_0     (rsp_combined_0),
      .rsp_combined_1     (rsp_combined_1),
      .rsp_combined_2     (rsp_combined_2),
      .rsp_combined_3     (rsp_combined_3),
      .rsp_combined_valid (rsp_combined_valid)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void rebuild_gold(cell_id_type cid);
      lfsr_type x1;
      lfsr_type x2;
      logic     f1;
      logic     f2;
      x1 = lfsr_type'(1);
      x2 = lfsr_type'(cid);
      for (int n = 0; n < GOLD_DISCARD + 4*BLOCK_LENGTH; n++) begin
         f1 = x1[3] ^ x1[0];
         f2 = x2[3] ^ x2[2] ^ x2[1] ^ x2[0];
         if (n >= GOLD_DISCARD) begin
            gold_bits[n-GOLD_DISCARD] = x1[0] ^ x2[0];
         end
         x1 = {f1, x1[LFSR_WIDTH-1:1]};
         x2 = {f2, x2[LFSR_WIDTH-1:1]};
      end
   endfunction

   function automatic rsp_word_type descramble_word(soft_type x);
      rsp_word_type w;
      soft_type  d [NUM_HYP];
      soft_type  c [NUM_HYP];
      sum_type   s;
      int        m;
      int        j;
      logic      first;
      logic      cvalid;
      m      = block_pos;
      j      = m % CHUNK_LENGTH;
      first  = (m < CHUNK_LENGTH);
      cvalid = (m >= 3*CHUNK_LENGTH);
      for (int h = 0; h < NUM_HYP; h++) begin
         d[h] = x;
         if (gold_bits[h*BLOCK_LENGTH + m]) begin
            // negation of the most negative value clips
            d[h] = (x == SOFT_MIN) ? SOFT_MAX : -x;
         end
         if (first) begin
            s = d[h];
         end else begin
            s = chunk_sums[h*CHUNK_LENGTH + j] + d[h];
         end
         chunk_sums[h*CHUNK_LENGTH + j] = s;
         c[h] = cvalid ? soft_type'(s >>> 2) : soft_type'(0);
      end
      w.position   = pos_type'(m);
      w.descr_0    = d[0];
      w.descr_1    = d[1];
      w.descr_2    = d[2];
      w.descr_3    = d[3];
      w.comb_0     = c[0];
      w.comb_1     = c[1];
      w.comb_2     = c[2];
      w.comb_3     = c[3];
      w.comb_valid = cvalid;
      block_pos = (m == BLOCK_LENGTH-1) ? 0 : m + 1;
      return w;
   endfunction

   function automatic soft_type pick_soft(bit extreme_only);
      int sel;
      sel = $urandom_range(0, 15);
      if (extreme_only) begin
         return $urandom_range(0, 1) ? SOFT_MIN : SOFT_MAX;
      end
      case (sel)
         0, 1:    return SOFT_MIN;
         2, 3:    return SOFT_MAX;
         4:       return soft_type'(0);
         5:       return soft_type'(-1);
         6:       return SOFT_MIN + soft_type'(1);
         default: return soft_type'($urandom);
      endcase
   endfunction

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // sender: one word held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (soft_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_soft_value <= soft_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_word_type act;
      rsp_word_type exp_w;
      req_took <= req_valid && !req_stall;
      csr_took <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            rebuild_gold(csr_cell_id);
         end
         if (rsp_valid && !rsp_stall) begin
            act = '{rsp_position, rsp_descrambled_0, rsp_descrambled_1, rsp_descrambled_2,
                    rsp_descrambled_3, rsp_combined_0, rsp_combined_1, rsp_combined_2,
                    rsp_combined_3, rsp_combined_valid};
            if (expected_words.size() == 0) begin
               $error("rsp word with no expectation, position %0d", rsp_position);
               mismatch_count++;
            end else begin
               exp_w = expected_words.pop_front();
               check_field("position", exp_w.position, act.position);
               check_field("descrambled_0", $signed(exp_w.descr_0), $signed(act.descr_0));
               check_field("descrambled_1", $signed(exp_w.descr_1), $signed(act.descr_1));
               check_field("descrambled_2", $signed(exp_w.descr_2), $signed(act.descr_2));
               check_field("descrambled_3", $signed(exp_w.descr_3), $signed(act.descr_3));
               check_field("combined_0", $signed(exp_w.comb_0), $signed(act.comb_0));
               check_field("combined_1", $signed(exp_w.comb_1), $signed(act.comb_1));
               check_field("combined_2", $signed(exp_w.comb_2), $signed(act.comb_2));
               check_field("combined_3", $signed(exp_w.comb_3), $signed(act.comb_3));
               check_field("combined_valid", exp_w.comb_valid, act.comb_valid);
            end
         end
         if (req_valid && !req_stall) begin
            expected_words = {expected_words, descramble_word(req_soft_value)};
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic drain();
      while (soft_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_cell(cell_id_type v);
      @(negedge clock);
      csr_cell_id <= v;
      csr_valid   <= 1'b1;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_soft(soft_type v);
      soft_queue = {soft_queue, v};
   endtask

   task automatic push_random(int count, bit extreme_only);
      for (int i = 0; i < count; i++) begin
         queue_soft(pick_soft(extreme_only));
      end
   endtask

   initial begin
      soft_type directed_vals [22];
      directed_vals = '{SOFT_MIN, SOFT_MAX, 16'sd0, -16'sd1, 16'sd1, SOFT_MIN + 16'sd1,
                        SOFT_MAX - 16'sd1, 16'sh5555, soft_type'(16'hAAAA), SOFT_MIN,
                        SOFT_MIN, SOFT_MIN, SOFT_MIN, SOFT_MAX, SOFT_MAX, SOFT_MAX,
                        16'sd0, -16'sd2, 16'sd2, soft_type'(16'h8001), 16'sh7ffe, SOFT_MIN};
      rebuild_gold(cell_id_type'(CELL_ID_RESET));
      block_pos = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 7;
      recv_stall_pct = 45;
      foreach (directed_vals[i]) queue_soft(directed_vals[i]);
      drain();
      write_cell(cell_id_type'(0));
      push_random(400, 1'b0);
      drain();

      send_idle_pct  = 45;
      recv_stall_pct = 7;
      write_cell(cell_id_type'(503));
      push_random(350, 1'b0);
      drain();
      // same value again still restarts the generator
      write_cell(cell_id_type'(503));

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      push_random(480, 1'b1);
      drain();
      write_cell(cell_id_type'(511));
      push_random(170, 1'b0);
      // sender holds off until the pipeline has emptied
      drain();
      push_random(170, 1'b0);
      drain();
      write_cell(cell_id_type'($urandom_range(0, 503)));
      push_random(100, 1'b0);
      drain();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> pbch_gold_descrambler_top.f
design/pbchd_pkg.sv
design/pbchd_ram.sv
design/pbch_gold_descrambler_top.sv
dv/tb_pbch_gold_descrambler_top.sv
